[rtl/core/mf3_pkg.sv]
// ----------------------------------------------------------------------------
// mf3_pkg: shared types and constants of the 3x3 median filter
// Pixel, position and line memory entry types, plus configuration codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mf3_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = 12;
	localparam int PIX_W     = 8;
	localparam int FW_W      = 11;
	localparam int FH_W      = 12;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 1;
	localparam int WIN_N     = 9;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [COL_W-1:0] col_t;
	typedef logic [ROW_W-1:0] row_t;
	typedef pix_t [WIN_N-1:0] win_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// one line memory entry: the row above and the row above that
	typedef struct packed {
		pix_t prev_row;
		pix_t older_row;
	} line_entry_t;

	// frame geometry as last column / last row
	typedef struct packed {
		col_t last_col;
		row_t last_row;
	} geom_t;

	// position tag that travels with a result
	typedef struct packed {
		row_t center_row;
		col_t center_col;
		logic last_of_frame;
	} meta_t;

endpackage

`default_nettype wire

[rtl/core/mf3_line_ram.sv]
// ----------------------------------------------------------------------------
// mf3_line_ram: line memory of the 3x3 median filter
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_line_ram
	import mf3_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        rd_en,
	input  wire col_t        rd_addr,
	output line_entry_t      rd_data,
	input  wire logic        wr_en,
	input  wire col_t        wr_addr,
	input  wire line_entry_t wr_data
);

	line_entry_t mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/mf3_window.sv]
// ----------------------------------------------------------------------------
// mf3_window: position counters, line memory access and 3x3 window
// Reads the line entry of the incoming column, writes it back shifted by one
// row and slides the window one column; tags interior positions.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_window
	import mf3_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire geom_t geom,
	input  wire logic  restart,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire pix_t  pixel,
	output logic       win_valid,
	input  wire logic  win_ready,
	output win_t       win,
	output meta_t      win_meta
);

	col_t        col_q;
	row_t        row_q;
	logic        v_s1;
	logic        emit_s1;
	pix_t        px_s1;
	col_t        col_s1;
	meta_t       meta_s1;
	logic        v_s2;
	win_t        win_q;
	meta_t       meta_s2;
	line_entry_t rd_data;
	logic        accept;
	logic        take_s2;
	logic        move_s1;

	assign take_s2  = !v_s2 || win_ready;
	assign move_s1  = v_s1 && take_s2;
	assign in_ready = !v_s1 || take_s2;
	assign accept   = in_valid && in_ready;

	// raster position of the next pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q == geom.last_col) begin
				col_q <= '0;
				row_q <= (row_q == geom.last_row) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// read stage: memory data returns with the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1                 <= pixel;
			col_s1                <= col_q;
			emit_s1               <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
			meta_s1.center_row    <= row_q - ROW_W'(1);
			meta_s1.center_col    <= col_q - COL_W'(1);
			meta_s1.last_of_frame <= (row_q == geom.last_row) && (col_q == geom.last_col);
		end
	end

	mf3_line_ram u_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (move_s1),
		.wr_addr (col_s1),
		.wr_data ('{prev_row: px_s1, older_row: rd_data.prev_row})
	);

	// window stage: slide one column, newest column on the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (take_s2) begin
			v_s2 <= v_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= rd_data.older_row;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= rd_data.prev_row;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= px_s1;
			meta_s2  <= meta_s1;
		end
	end

	assign win_valid = v_s2;
	assign win       = win_q;
	assign win_meta  = meta_s2;

endmodule

`default_nettype wire

[rtl/core/mf3_median.sv]
// ----------------------------------------------------------------------------
// mf3_median: pipelined median of nine
// Sort each row of three, take max of minima, median of medians and min of
// maxima, then the median of those three; output register at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_median
	import mf3_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire win_t  win,
	input  wire meta_t meta,
	output logic       out_valid,
	input  wire logic  out_ready,
	output pix_t       median,
	output meta_t      out_meta
);

	function automatic pix_t min2(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(input pix_t a, input pix_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	win_t  sort_s3;
	meta_t meta_s3;
	logic  v_s3;
	pix_t  lo_s4;
	pix_t  md_s4;
	pix_t  hi_s4;
	meta_t meta_s4;
	logic  v_s4;
	pix_t  med_q;
	meta_t meta_q;
	logic  v_q;
	logic  take_s3;
	logic  take_s4;
	logic  take_q;

	assign take_q   = !v_q || out_ready;
	assign take_s4  = !v_s4 || take_q;
	assign take_s3  = !v_s3 || take_s4;
	assign in_ready = take_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (take_s3) begin
				v_s3 <= in_valid;
			end
			if (take_s4) begin
				v_s4 <= v_s3;
			end
			if (take_q) begin
				v_q <= v_s4;
			end
		end
	end

	// row sort: slot 0 min, 1 median, 2 max of each row
	always_ff @(posedge clk) begin
		if (take_s3 && in_valid) begin
			for (int r = 0; r < 3; r++) begin
				sort_s3[3*r]   <= min2(min2(win[3*r], win[3*r+1]), win[3*r+2]);
				sort_s3[3*r+1] <= med3(win[3*r], win[3*r+1], win[3*r+2]);
				sort_s3[3*r+2] <= max2(max2(win[3*r], win[3*r+1]), win[3*r+2]);
			end
			meta_s3 <= meta;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s4 && v_s3) begin
			lo_s4   <= max2(max2(sort_s3[0], sort_s3[3]), sort_s3[6]);
			md_s4   <= med3(sort_s3[1], sort_s3[4], sort_s3[7]);
			hi_s4   <= min2(min2(sort_s3[2], sort_s3[5]), sort_s3[8]);
			meta_s4 <= meta_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (take_q && v_s4) begin
			med_q  <= med3(lo_s4, md_s4, hi_s4);
			meta_q <= meta_s4;
		end
	end

	assign out_valid = v_q;
	assign median    = med_q;
	assign out_meta  = meta_q;

endmodule

`default_nettype wire

[rtl/core/median_filter_3x3_unit.sv]
// ----------------------------------------------------------------------------
// median_filter_3x3_unit: streaming 3x3 median filter over 8-bit pixels
// Path: read, window, row sort, cross-row merge and output registers.
// Throughput: one pixel per cycle, set by the single line memory port pair
// (one read and one write every cycle); downstream stalls back up the pipe.
// Reset: position returns to row 0, column 0, width 640, height 480; the
// line memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module median_filter_3x3_unit
	import mf3_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration write port
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	// pixel input
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire pix_t                 pixel,
	// result output
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output pix_t                      median,
	output row_t                      center_row,
	output col_t                      center_col,
	output logic                      last_of_frame
);

	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic            restart;
	geom_t           geom;
	logic            win_valid;
	logic            win_ready;
	win_t            win;
	meta_t           win_meta;
	meta_t           out_meta;

	// Configuration registers. Any write restarts the frame at the top-left
	// corner; the line memory keeps its contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_W'(640);
			frame_height_q <= FH_W'(480);
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				default:          ;
			endcase
		end
	end

	assign restart = cfg_wr_en;

	// Clamp geometry: width to 3..MAX_WIDTH, height to at least 3, and hand
	// it on as last column and last row so the counters compare directly.
	always_comb begin
		if (frame_width_q < FW_W'(3)) begin
			geom.last_col = COL_W'(2);
		end else if (frame_width_q > FW_W'(MAX_WIDTH)) begin
			geom.last_col = COL_W'(MAX_WIDTH - 1);
		end else begin
			geom.last_col = COL_W'(frame_width_q - FW_W'(1));
		end
		if (frame_height_q < FH_W'(3)) begin
			geom.last_row = ROW_W'(2);
		end else begin
			geom.last_row = ROW_W'(frame_height_q - FH_W'(1));
		end
	end

	// Front end: counters, line memory read-modify-write, window slide.
	// In a frame, consecutive pixels touch different columns (width is at
	// least three), so a read never meets the pending write of the same entry.
	mf3_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.restart   (restart),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel     (pixel),
		.win_valid (win_valid),
		.win_ready (win_ready),
		.win       (win),
		.win_meta  (win_meta)
	);

	// Back end: three-stage median network ending in the output register.
	mf3_median u_median (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (win_valid),
		.in_ready  (win_ready),
		.win       (win),
		.meta      (win_meta),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.median    (median),
		.out_meta  (out_meta)
	);

	assign center_row    = out_meta.center_row;
	assign center_col    = out_meta.center_col;
	assign last_of_frame = out_meta.last_of_frame;

endmodule

`default_nettype wire

[tb/sv/mf3_median_checker.sv]
// ----------------------------------------------------------------------------
// mf3_median_checker: result predictor and comparator for the median filter
// Watches the register port and both pixel channels, keeps its own copy of
// the line stores, window and position, and checks every result beat in order.
// ----------------------------------------------------------------------------
module mf3_median_checker
	import mf3_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	input  wire logic                 in_ready,
	input  wire pix_t                 pixel,
	input  wire logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire pix_t                 median,
	input  wire row_t                 center_row,
	input  wire col_t                 center_col,
	input  wire logic                 last_of_frame,
	output int                        mismatches,
	output int                        pending,
	output int                        checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		pix_t med;
		row_t row;
		col_t col;
		logic last;
	} filtered_t;

	filtered_t         expected_q[$];
	pix_t              row_above  [MAX_WIDTH];
	pix_t              row_above2 [MAX_WIDTH];
	win_t              win;
	int unsigned       next_col;
	int unsigned       next_row;
	logic [FW_W-1:0]   width_cfg;
	logic [FH_W-1:0]   height_cfg;

	// rank selection: the value with at most four below it and at least five
	// at or below it is the fifth smallest
	function automatic pix_t rank_median(input win_t v);
		int below;
		int at_or_below;
		for (int i = 0; i < WIN_N; i++) begin
			below = 0;
			at_or_below = 0;
			for (int j = 0; j < WIN_N; j++) begin
				if (v[j] < v[i]) below++;
				if (v[j] <= v[i]) at_or_below++;
			end
			if (below <= 4 && at_or_below >= 5) return v[i];
		end
		return v[0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		int unsigned w, h, c, r;
		pix_t        top_px, mid_px;
		filtered_t   exp_r, got;
		if (!arst_n) begin
			for (int i = 0; i < MAX_WIDTH; i++) begin
				row_above[i]  = '0;
				row_above2[i] = '0;
			end
			win        = '0;
			next_col   = 0;
			next_row   = 0;
			width_cfg  = FW_W'(640);
			height_cfg = FH_W'(480);
			expected_q.delete();
			mismatches = 0;
			pending    = 0;
			checked    = 0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == REG_FRAME_WIDTH) width_cfg = cfg_data[FW_W-1:0];
				else if (cfg_index == REG_FRAME_HEIGHT) height_cfg = cfg_data[FH_W-1:0];
				next_col = 0;
				next_row = 0;
			end

			if (in_valid && in_ready) begin
				w = (width_cfg < 3) ? 3 : ((width_cfg > MAX_WIDTH) ? MAX_WIDTH : width_cfg);
				h = (height_cfg < 3) ? 3 : height_cfg;
				if (next_col >= w) next_col = 0;
				if (next_row >= h) next_row = 0;
				c = next_col;
				r = next_row;
				top_px        = row_above2[c];
				mid_px        = row_above[c];
				row_above2[c] = mid_px;
				row_above[c]  = pixel;
				// newest column enters at the top, oldest drops out of the bottom
				win = {pixel, mid_px, top_px, win[WIN_N-1:3]};
				if (r >= 2 && c >= 2) begin
					exp_r.med  = rank_median(win);
					exp_r.row  = row_t'(r - 1);
					exp_r.col  = col_t'(c - 1);
					exp_r.last = (r == h - 1) && (c == w - 1);
					expected_q.push_back(exp_r);
				end
				if (c + 1 >= w) begin
					next_col = 0;
					next_row = (r + 1 >= h) ? 0 : r + 1;
				end else begin
					next_col = c + 1;
				end
			end

			if (out_valid && out_ready) begin
				got = {median, center_row, center_col, last_of_frame};
				if (expected_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result median %0d at row %0d col %0d",
							$time, got.med, got.row, got.col);
					mismatches++;
				end else begin
					exp_r = expected_q.pop_front();
					checked++;
					if (got.med !== exp_r.med || got.row !== exp_r.row ||
							got.col !== exp_r.col || got.last !== exp_r.last) begin
						if (mismatches < 10) begin
							$write("%0t: mismatch (expected/actual) median %0d/%0d row %0d/%0d ",
								$time, exp_r.med, got.med, exp_r.row, got.row);
							$display("col %0d/%0d last %0b/%0b",
								exp_r.col, got.col, exp_r.last, got.last);
						end
						mismatches++;
					end
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: stream test of the 3x3 median filter unit
// Drives frames of random and patterned pixels through many small frame
// geometries from the clamped 3x3 minimum upward, plus an over-range width
// and the tallest height, while the pixel source and result sink stall in
// turn; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;
	import mf3_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_ITEMS = 900;
	// margin after the last predicted result; leave it wide
	localparam int QUIET_CYCLES = 12;

	// pixel patterns for one stretch of stimulus
	typedef enum int {
		PIX_ANY,
		PIX_EXTREME,
		PIX_NEAR,
		PIX_ONE_HOT
	} pix_style_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 cfg_wr_en  = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = REG_FRAME_WIDTH;
	logic [CFG_W-1:0]     cfg_data   = '0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	pix_t                 pixel      = '0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	pix_t                 median;
	row_t                 center_row;
	col_t                 center_col;
	logic                 last_of_frame;

	int mismatches;
	int pending;
	int checked;

	int gap_pct     = 0;
	int stall_pct   = 0;
	int cycles      = 0;
	int pixels_sent = 0;
	int cfg_writes  = 0;
	// effective geometry as the block sees it; used to size the stimulus
	int frame_w     = 640;
	int frame_h     = 480;

	median_filter_3x3_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.pixel         (pixel),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.median        (median),
		.center_row    (center_row),
		.center_col    (center_col),
		.last_of_frame (last_of_frame)
	);

	mf3_median_checker check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.pixel         (pixel),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.median        (median),
		.center_row    (center_row),
		.center_col    (center_col),
		.last_of_frame (last_of_frame),
		.mismatches    (mismatches),
		.pending       (pending),
		.checked       (checked)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop in case the pipe hangs or results go missing
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected", cycles, pending);
			$display("simulation failed");
			$finish;
		end
	end

	// result sink: stall at random, re-decided every cycle on the falling edge
	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= stall_pct);
	end

	function automatic pix_t pick_pixel(input pix_style_t style);
		case (style)
			PIX_ANY:     return pix_t'($urandom_range(255));
			PIX_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
			// many ties around one level stress the rank selection
			PIX_NEAR:    return pix_t'(127 + $urandom_range(2));
			default:     return pix_t'(8'h01 << $urandom_range(7));
		endcase
	endfunction

	// Send one pixel beat. Called at a falling edge; returns at the falling
	// edge after the beat, with valid still high so that back-to-back beats
	// never drop valid in between.
	task automatic push_pixel(input pix_t p);
		while ($urandom_range(99) < gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		pixel    = p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		pixels_sent++;
	endtask

	task automatic stream(input int count, input pix_style_t style);
		for (int k = 0; k < count; k++) push_pixel(pick_pixel(style));
	endtask

	// Drop valid, wait for every predicted result, then let the border
	// pixels still in the pipe drain before touching the registers.
	task automatic settle();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	// One register write; the block restarts its frame at row 0, column 0.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		logic [FW_W-1:0] w_field;
		w_field   = val[FW_W-1:0];
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cfg_writes++;
		// track the clamped geometry so frames can be sized
		if (idx == REG_FRAME_WIDTH)
			frame_w = (w_field < 3) ? 3 : ((w_field > MAX_WIDTH) ? MAX_WIDTH : w_field);
		else
			frame_h = (val < 3) ? 3 : val;
	endtask

	task automatic set_geometry(input logic [CFG_W-1:0] wdata, input logic [CFG_W-1:0] hdata);
		settle();
		write_reg(REG_FRAME_WIDTH, wdata);
		write_reg(REG_FRAME_HEIGHT, hdata);
	endtask

	initial begin : stimulus
		int               phase_start;
		int               pick;
		int               count;
		logic [CFG_W-1:0] wd;
		logic [CFG_W-1:0] hd;
		pix_style_t       style;

		// hold reset low from the start, release on a falling edge
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Reset geometry is 640x480: stream part of the first row, which
		// yields no result, then restart the frame by a register write.
		stream(40, PIX_ANY);

		// Directed: width and height below the minimum both act as 3, so
		// each 3x3 frame yields one result, flagged last of frame. First
		// frame has five 255s (median 255), the second five 0s (median 0),
		// which also exercises the wrap into a new frame.
		set_geometry(12'h000, 12'h001);
		for (int k = 0; k < 18; k++)
			push_pixel((((k % 9) % 2 == 0) == (k < 9)) ? 8'hFF : 8'h00);

		// Random: receiver stalls hard first, then the sender idles hard,
		// then neither.
		for (int ph = 0; ph < 3; ph++) begin
			gap_pct   = (ph == 0) ? 27 : ((ph == 1) ? 72 : 0);
			stall_pct = (ph == 0) ? 72 : ((ph == 1) ? 27 : 0);
			phase_start = pixels_sent;
			while (pixels_sent - phase_start < RANDOM_ITEMS / 3) begin
				pick = $urandom_range(7);
				// mostly reprogram; sometimes just keep streaming mid-frame
				if (pick < 6) begin
					case ($urandom_range(7))
						0:       wd = CFG_W'($urandom_range(2));
						// bit 11 is not part of the width field
						1:       wd = 12'h800 | CFG_W'($urandom_range(3, 9));
						2:       wd = 12'h800 | CFG_W'($urandom_range(2));
						default: wd = CFG_W'($urandom_range(3, 10));
					endcase
					hd = ($urandom_range(5) == 0) ? CFG_W'($urandom_range(2))
						: CFG_W'($urandom_range(3, 7));
					settle();
					if (pick != 4) write_reg(REG_FRAME_WIDTH, wd);
					if (pick != 5) write_reg(REG_FRAME_HEIGHT, hd);
				end
				style = pix_style_t'($urandom_range(3));
				count = frame_w * frame_h * $urandom_range(1, 3);
				// cut some frames short so the next write lands mid-frame
				if ($urandom_range(3) == 0) count += $urandom_range(frame_w * frame_h - 1);
				stream(count, style);
			end
		end

		// Large geometries, no idling: an over-range width that clamps to
		// 1024 (first row only, so no result), then the tallest frame with
		// three-pixel rows, run a few rows deep.
		set_geometry(12'h7FF, 12'd3);
		stream(40, PIX_ANY);
		set_geometry(12'd3, 12'hFFF);
		stream(3 * 6, PIX_ANY);

		settle();
		$display("%0d pixels sent, %0d filtered results checked, %0d register writes",
			pixels_sent, checked, cfg_writes);
		$display("small random frames from clamped 3x3 up, over-range width, tallest height");
		if (mismatches == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches, pending);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/mf3_pkg.sv
rtl/core/mf3_line_ram.sv
rtl/core/mf3_window.sv
rtl/core/mf3_median.sv
rtl/core/median_filter_3x3_unit.sv
tb/sv/mf3_median_checker.sv
tb/sv/tb.sv
